// ----- src/integer_literal_parser_assert.svh -----
// ----------------------------------------------------------------------------
// Integer literal parser assertion macros
// Shorthand for clocked, reset-gated concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// Same-cycle implication, checked on clk_i, disabled during reset.
`define ILP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("integer_literal_parser: same-cycle check failed");

// Next-cycle implication, checked on clk_i, disabled during reset.
`define ILP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("integer_literal_parser: next-cycle check failed");

`endif

// ----- src/ilp_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser package
// Payload types, radix codes and character decode helpers.
// ----------------------------------------------------------------------------
package ilp_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_LATER  = 2'd2
  } pos_e;

  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChLowA       = 8'h61;
  localparam logic [7:0] ChLowF       = 8'h66;
  localparam logic [7:0] ChUpA        = 8'h41;
  localparam logic [7:0] ChUpF        = 8'h46;
  localparam logic [7:0] ChLowX       = 8'h78;
  localparam logic [7:0] ChUpX        = 8'h58;
  localparam logic [7:0] ChLowO       = 8'h6F;
  localparam logic [7:0] ChUpO        = 8'h4F;
  localparam logic [7:0] ChLowB       = 8'h62;
  localparam logic [7:0] ChUpB        = 8'h42;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } ilp_char_t;

  typedef struct packed {
    logic [63:0] literal_value;
    logic        bad_digit;
    logic [1:0]  radix_code;
  } ilp_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  // Decode a character into a digit value; ok is low for non-digits.
  function automatic digit_t digit_of(input logic [7:0] ch);
    digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (ch >= ChZero && ch <= ChNine) begin
      d.value = ch[3:0];
    end else if ((ch >= ChLowA && ch <= ChLowF) || (ch >= ChUpA && ch <= ChUpF)) begin
      d.value = ch[3:0] + 4'd9;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  // Radix selected by a prefix letter, decimal when the letter is none.
  function automatic radix_e prefix_radix(input logic [7:0] ch);
    radix_e r;
    r = RADIX_DEC;
    if (ch == ChLowX || ch == ChUpX) begin
      r = RADIX_HEX;
    end else if (ch == ChLowO || ch == ChUpO) begin
      r = RADIX_OCT;
    end else if (ch == ChLowB || ch == ChUpB) begin
      r = RADIX_BIN;
    end
    return r;
  endfunction

  // Digit value too large for the radix.
  function automatic logic beyond_radix(input radix_e r, input logic [3:0] v);
    logic bad;
    unique case (r)
      RADIX_DEC: bad = (v > 4'd9);
      RADIX_HEX: bad = 1'b0;
      RADIX_OCT: bad = (v > 4'd7);
      RADIX_BIN: bad = (v > 4'd1);
      default:   bad = 1'b1;
    endcase
    return bad;
  endfunction

endpackage

// ----- src/ilp_if.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser channels
// Valid/ready channels for character items and result items.
// ----------------------------------------------------------------------------
interface ilp_char_if;
  logic              valid;
  logic              ready;
  ilp_pkg::ilp_char_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ilp_result_if;
  logic                valid;
  logic                ready;
  ilp_pkg::ilp_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/integer_literal_parser.sv -----
// ----------------------------------------------------------------------------
// Integer literal parser
// Folds a character stream into one 64-bit literal value per token.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one character item per handshake (char_code, last_char).
//   A token is the run of items up to and including one with last_char set.
//   A leading "0x", "0o" or "0b" (either case) selects base 16, 8 or 2;
//   otherwise the token is decimal. Underscores are skipped.
//   out_o carries one result item per token: literal_value (mod 2^64),
//   bad_digit and radix_code (0 dec, 1 hex, 2 oct, 3 bin).
// Timing:
//   One item per cycle sustained while out_o keeps up. An item lands
//   in the input register, then the shift-and-add step folds it into the
//   accumulator and, for a last item, into the result register on out_o.
// Reset:
//   rst_ni clears both stages and the parse state: the next item starts
//   a new token.
// Stall:
//   While a result waits on out_o, non-last items keep flowing; a last
//   item holds in the input register until the result register frees up.
// ----------------------------------------------------------------------------
`include "integer_literal_parser_assert.svh"

module integer_literal_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  ilp_char_if.sink            in_i,
  ilp_result_if.source        out_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;

  // Parse state
  ilp_pkg::pos_e   pos_q,   pos_d;
  ilp_pkg::radix_e radix_q, radix_d;
  logic [63:0]     acc_q,   acc_d;
  logic            err_q,   err_d;
  logic            lz_q,    lz_d;

  // Result register
  logic                 out_valid_q;
  ilp_pkg::ilp_result_t out_data_q;

  logic                 proceed;
  logic                 consumed;
  logic                 use_digit;
  ilp_pkg::radix_e      pfx_radix;
  ilp_pkg::digit_t      dig;
  logic [63:0]          scaled;

  // Advance the input stage unless a last item would overrun a waiting result.
  assign proceed     = in_valid_q && (!last_q || !out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || proceed;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    pfx_radix = ilp_pkg::prefix_radix(char_q);
    dig       = ilp_pkg::digit_of(char_q);

    // Prefix letter: only right after a leading zero.
    consumed  = (pos_q == ilp_pkg::POS_SECOND) && lz_q && (pfx_radix != ilp_pkg::RADIX_DEC);
    use_digit = !consumed && (char_q != ilp_pkg::ChUnderscore);
    radix_d   = consumed ? pfx_radix : radix_q;

    // Multiply by the base as shifts and adds.
    unique case (radix_q)
      ilp_pkg::RADIX_DEC: scaled = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0};
      ilp_pkg::RADIX_HEX: scaled = {acc_q[59:0], 4'b0000};
      ilp_pkg::RADIX_OCT: scaled = {acc_q[60:0], 3'b000};
      ilp_pkg::RADIX_BIN: scaled = {acc_q[62:0], 1'b0};
      default:            scaled = acc_q;
    endcase

    acc_d = acc_q;
    err_d = err_q;
    if (use_digit) begin
      // Non-digits fold in as zero but still flag the token.
      acc_d = scaled + {60'd0, (dig.ok ? dig.value : 4'd0)};
      err_d = err_q || !dig.ok || ilp_pkg::beyond_radix(radix_q, dig.value);
    end

    lz_d = lz_q;
    if (pos_q == ilp_pkg::POS_FIRST) begin
      pos_d = ilp_pkg::POS_SECOND;
      lz_d  = (char_q == ilp_pkg::ChZero);
    end else begin
      pos_d = ilp_pkg::POS_LATER;
    end
  end

  // Input register: take a new item whenever the stage is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (proceed) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.data.char_code;
      last_q <= in_i.data.last_char;
    end
  end

  // Parse state: fold the item in, or drop back to a fresh token after the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= ilp_pkg::POS_FIRST;
      radix_q <= ilp_pkg::RADIX_DEC;
      acc_q   <= 64'd0;
      err_q   <= 1'b0;
      lz_q    <= 1'b0;
    end else if (proceed) begin
      if (last_q) begin
        pos_q   <= ilp_pkg::POS_FIRST;
        radix_q <= ilp_pkg::RADIX_DEC;
        acc_q   <= 64'd0;
        err_q   <= 1'b0;
        lz_q    <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        radix_q <= radix_d;
        acc_q   <= acc_d;
        err_q   <= err_d;
        lz_q    <= lz_d;
      end
    end
  end

  // Result register: load on a token's last item, hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proceed && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && last_q) begin
      out_data_q.literal_value <= acc_d;
      out_data_q.bad_digit     <= err_d;
      out_data_q.radix_code    <= radix_d;
    end
  end

  `ILP_ASSERT_NEXT(a_result_only_from_last, !out_valid_q && !(proceed && last_q), !out_valid_q)
  `ILP_ASSERT_NEXT(a_clear_after_token, proceed && last_q, pos_q == ilp_pkg::POS_FIRST && acc_q == 64'd0)
  `ILP_ASSERT_NOW(a_prefix_after_second, radix_q != ilp_pkg::RADIX_DEC, pos_q == ilp_pkg::POS_LATER)

endmodule
